### hw/rtl/tksd_pkg.sv
`default_nettype none
package tksd_pkg;

    // Control bytes
    localparam logic [7:0] KEY_INTR = 8'd3;
    localparam logic [7:0] KEY_BS   = 8'd8;
    localparam logic [7:0] KEY_TAB  = 8'd9;
    localparam logic [7:0] KEY_LF   = 8'd10;
    localparam logic [7:0] KEY_CR   = 8'd13;
    localparam logic [7:0] KEY_ESC  = 8'd27;
    localparam logic [7:0] KEY_DEL  = 8'd127;

    // Sequence characters
    localparam logic [7:0] CHR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHR_TILDE    = 8'h7E;
    localparam logic [7:0] CHR_A        = 8'h41;
    localparam logic [7:0] CHR_B        = 8'h42;
    localparam logic [7:0] CHR_C        = 8'h43;
    localparam logic [7:0] CHR_D        = 8'h44;
    localparam logic [7:0] CHR_F        = 8'h46;
    localparam logic [7:0] CHR_H        = 8'h48;
    localparam logic [7:0] CHR_J        = 8'h4A;
    localparam logic [7:0] CHR_ONE      = 8'h31;
    localparam logic [7:0] CHR_THREE    = 8'h33;
    localparam logic [7:0] CHR_FOUR     = 8'h34;

    // Keys pending on a tilde
    localparam logic [1:0] TKEY_NONE   = 2'd0;
    localparam logic [1:0] TKEY_HOME   = 2'd1;
    localparam logic [1:0] TKEY_END    = 2'd2;
    localparam logic [1:0] TKEY_DELETE = 2'd3;

    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;

    typedef enum logic [3:0] {
        EV_CHAR      = 4'd0,
        EV_ESCAPE    = 4'd1,
        EV_UP        = 4'd2,
        EV_DOWN      = 4'd3,
        EV_LEFT      = 4'd4,
        EV_RIGHT     = 4'd5,
        EV_HOME      = 4'd6,
        EV_END       = 4'd7,
        EV_DELETE    = 4'd8,
        EV_CLEAR     = 4'd9,
        EV_TAB       = 4'd10,
        EV_BACKSPACE = 4'd11,
        EV_NEWLINE   = 4'd12,
        EV_CTRL      = 4'd13,
        EV_UNKNOWN   = 4'd14,
        EV_INTERRUPT = 4'd15
    } t_event_kind;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_TILDE   = 3'd3,
        MODE_UTF8    = 3'd4,
        MODE_SKIP    = 3'd5,
        MODE_CR      = 3'd6,
        MODE_DISCARD = 3'd7
    } t_mode;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       chunk_end;
    } t_in_word;

    typedef struct packed {
        t_event_kind event_kind;
        logic [20:0] code_value;
    } t_out_word;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  tilde_key;
        logic [1:0]  utf8_left;
        logic [20:0] cp_accum;
    } t_dec_state;

endpackage
`default_nettype wire

### hw/rtl/tksd_decode.sv
`default_nettype none
module tksd_decode (
    input  var tksd_pkg::t_in_word   i_word,
    input  var tksd_pkg::t_dec_state i_state,
    output tksd_pkg::t_dec_state     o_state,
    output logic                     o_emit,
    output tksd_pkg::t_out_word      o_word
);
    import tksd_pkg::*;

    logic [7:0]  b;
    logic        chunk_end;
    t_dec_state  st_state;
    logic        st_emit;
    t_event_kind st_kind;
    logic [20:0] st_code;
    logic        u_bad;
    logic [1:0]  u_left;
    logic [20:0] u_accum;

    assign b         = i_word.key_byte;
    assign chunk_end = i_word.chunk_end;

    // First byte of a new key
    always_comb begin
        st_state      = i_state;
        st_state.mode = MODE_IDLE;
        st_emit       = 1'b1;
        st_kind       = EV_UNKNOWN;
        st_code       = '0;
        if (b inside {[8'd32:8'd126]}) begin
            st_kind = EV_CHAR;
            st_code = {13'd0, b};
        end else if (b[7]) begin
            if (b inside {[8'hC2:8'hF4]}) begin
                st_emit       = 1'b0;
                st_state.mode = MODE_UTF8;
                if (b < 8'hE0) begin
                    st_state.utf8_left = 2'd1;
                    st_state.cp_accum  = {16'd0, b[4:0]};
                end else if (b < 8'hF0) begin
                    st_state.utf8_left = 2'd2;
                    st_state.cp_accum  = {17'd0, b[3:0]};
                end else begin
                    st_state.utf8_left = 2'd3;
                    st_state.cp_accum  = {18'd0, b[2:0]};
                end
            end
        end else if (b == KEY_ESC) begin
            if (chunk_end) begin
                st_kind = EV_ESCAPE;
            end else begin
                st_emit       = 1'b0;
                st_state.mode = MODE_ESC;
            end
        end else if (b == KEY_INTR) begin
            st_kind = EV_INTERRUPT;
        end else if (b == KEY_DEL || b == KEY_BS) begin
            st_kind = EV_BACKSPACE;
        end else if (b == KEY_TAB) begin
            st_kind = EV_TAB;
        end else if (b == KEY_LF) begin
            st_kind = EV_NEWLINE;
        end else if (b == KEY_CR) begin
            st_kind = EV_NEWLINE;
            if (!chunk_end) begin
                st_state.mode = MODE_CR;
            end
        end else if (b inside {[8'd1:8'd26]}) begin
            st_kind = EV_CTRL;
            st_code = {13'd0, b};
        end else begin
            // NUL and the upper control bytes: drop the rest of the burst
            st_state.mode      = chunk_end ? MODE_IDLE : MODE_DISCARD;
            st_state.tilde_key = TKEY_NONE;
        end
    end

    // UTF-8 continuation checks
    always_comb begin
        u_bad = (b[7:6] != 2'b10);
        if (!u_bad && i_state.cp_accum == '0) begin
            if (i_state.utf8_left == 2'd2 && b < 8'hA0) begin
                u_bad = 1'b1;
            end
            if (i_state.utf8_left == 2'd3 && b < 8'h90) begin
                u_bad = 1'b1;
            end
        end
        u_left  = i_state.utf8_left - 2'd1;
        u_accum = {i_state.cp_accum[14:0], b[5:0]};
    end

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_word  = '{event_kind: EV_CHAR, code_value: '0};
        case (i_state.mode)
            MODE_ESC: begin
                if (b == CHR_LBRACKET && !chunk_end) begin
                    o_state.mode = MODE_CSI;
                end else if (b == CHR_H) begin
                    o_state.mode     = MODE_IDLE;
                    o_emit           = 1'b1;
                    o_word.event_kind = EV_HOME;
                end else if (b == CHR_F) begin
                    o_state.mode     = MODE_IDLE;
                    o_emit           = 1'b1;
                    o_word.event_kind = EV_END;
                end else begin
                    o_state.mode      = chunk_end ? MODE_IDLE : MODE_DISCARD;
                    o_state.tilde_key = TKEY_NONE;
                    o_emit            = 1'b1;
                    o_word.event_kind = EV_UNKNOWN;
                end
            end
            MODE_CSI: begin
                o_state.mode = MODE_IDLE;
                o_emit       = 1'b1;
                case (b)
                    CHR_A:   o_word.event_kind = EV_UP;
                    CHR_B:   o_word.event_kind = EV_DOWN;
                    CHR_D:   o_word.event_kind = EV_LEFT;
                    CHR_C:   o_word.event_kind = EV_RIGHT;
                    CHR_H:   o_word.event_kind = EV_HOME;
                    CHR_F:   o_word.event_kind = EV_END;
                    CHR_J:   o_word.event_kind = EV_CLEAR;
                    CHR_ONE, CHR_FOUR, CHR_THREE: begin
                        if (chunk_end) begin
                            o_state.tilde_key = TKEY_NONE;
                            o_word.event_kind = EV_UNKNOWN;
                        end else begin
                            o_emit       = 1'b0;
                            o_state.mode = MODE_TILDE;
                            o_state.tilde_key = (b == CHR_ONE)  ? TKEY_HOME :
                                                (b == CHR_FOUR) ? TKEY_END  : TKEY_DELETE;
                        end
                    end
                    default: begin
                        o_state.mode      = chunk_end ? MODE_IDLE : MODE_DISCARD;
                        o_state.tilde_key = TKEY_NONE;
                        o_word.event_kind = EV_UNKNOWN;
                    end
                endcase
            end
            MODE_TILDE: begin
                o_emit            = 1'b1;
                o_state.tilde_key = TKEY_NONE;
                if (b == CHR_TILDE) begin
                    o_state.mode = MODE_IDLE;
                    o_word.event_kind = (i_state.tilde_key == TKEY_HOME) ? EV_HOME :
                                        (i_state.tilde_key == TKEY_END)  ? EV_END  : EV_DELETE;
                end else begin
                    o_state.mode      = chunk_end ? MODE_IDLE : MODE_DISCARD;
                    o_word.event_kind = EV_UNKNOWN;
                end
            end
            MODE_UTF8: begin
                o_state.utf8_left = u_left;
                if (u_bad) begin
                    o_state.cp_accum  = '0;
                    o_state.mode      = (u_left != 2'd0) ? MODE_SKIP : MODE_IDLE;
                    o_emit            = 1'b1;
                    o_word.event_kind = EV_UNKNOWN;
                end else if (u_left != 2'd0) begin
                    o_state.cp_accum = u_accum;
                end else begin
                    o_state.cp_accum = '0;
                    o_state.mode     = MODE_IDLE;
                    o_emit           = 1'b1;
                    if (u_accum > CP_MAX || (u_accum >= CP_SURR_LO && u_accum <= CP_SURR_HI)) begin
                        o_word.event_kind = EV_UNKNOWN;
                    end else begin
                        o_word.code_value = u_accum;
                    end
                end
            end
            MODE_SKIP: begin
                o_state.utf8_left = u_left;
                if (u_left == 2'd0) begin
                    o_state.mode = MODE_IDLE;
                end
            end
            MODE_CR: begin
                if (b == KEY_LF) begin
                    o_state.mode = MODE_IDLE;
                end else begin
                    o_state = st_state;
                    o_emit  = st_emit;
                    o_word  = '{event_kind: st_kind, code_value: st_code};
                end
            end
            MODE_DISCARD: begin
                if (chunk_end) begin
                    o_state.mode = MODE_IDLE;
                end
            end
            default: begin
                o_state = st_state;
                o_emit  = st_emit;
                o_word  = '{event_kind: st_kind, code_value: st_code};
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/terminal_key_sequence_decoder_top.sv
// Terminal key sequence decoder.
// Input channel: one raw terminal byte per word (key_byte) with chunk_end
// marking the last byte of a read burst; accepted when i_in_valid is high
// and o_in_stall is low. Output channel: one key event per word
// (event_kind, code_value); taken when o_out_valid is high and i_out_stall
// is low. Some bytes (ESC prefixes, UTF-8 lead bytes, LF after CR, bytes
// inside a discarded burst) produce no event at all.
// Path: an accepted byte is decoded from the input register and its
// event, if any, is loaded into the event register once that is free.
// Throughput: one byte per clock while the receiver does not stall,
// set by the single decode pass between input and event registers.
// Reset (synchronous, active low): drops both pipeline registers and
// returns the decoder to idle with no partial sequence or codepoint.
// While an event is stalled, the event register holds; the input register
// then holds its byte and o_in_stall rises, so no byte is lost.
`default_nettype none
module terminal_key_sequence_decoder_top (
    input  var logic               i_clk,
    input  var logic               i_rst_n,
    input  var logic               i_in_valid,
    output logic                   o_in_stall,
    input  var tksd_pkg::t_in_word i_in_data,
    output logic                   o_out_valid,
    input  var logic               i_out_stall,
    output tksd_pkg::t_out_word    o_out_data
);
    import tksd_pkg::*;

    logic       r_in_valid;
    t_in_word   r_in_word;
    logic       r_out_valid;
    t_out_word  r_out_word;
    t_dec_state r_state;
    t_dec_state n_state;
    logic       dec_emit;
    t_out_word  dec_word;
    logic       out_free;
    logic       take;

    // Event register can load when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign take       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

    tksd_decode u_decode (
        .i_word  (r_in_word),
        .i_state (r_state),
        .o_state (n_state),
        .o_emit  (dec_emit),
        .o_word  (dec_word)
    );

    // Input register: load whenever the current byte is not held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_data;
        end
    end

    // Decoder state advances only when a byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_IDLE, tilde_key: TKEY_NONE, utf8_left: 2'd0,
                         cp_accum: 21'd0};
        end else if (take) begin
            r_state <= n_state;
        end
    end

    // Event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= take && dec_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && dec_emit) begin
            r_out_word <= dec_word;
        end
    end

endmodule
`default_nettype wire
